// ===== design/binary_gps_frame_parser_assert.svh =====
// Assertion macros for the binary GPS frame parser checker.
// Expects signals clk and rst_n in the scope of each use.
`ifndef BINARY_GPS_FRAME_PARSER_ASSERT_SVH
`define BINARY_GPS_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BGFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgfp assertion failed");

// next-cycle implication, disabled in reset
`define BGFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgfp assertion failed");

`endif

// ===== design/bgfp_pkg.sv =====
// Types and constants of the binary GPS frame parser.
// No dependencies; used by the step logic, the top level, the checker and the testbench.
`default_nettype none

package bgfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hA0;
  localparam logic [7:0] SYNC_SECOND = 8'hA1;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] LOC_ID_RESET = 8'd168;

  typedef enum logic [2:0] {
    ST_MORE       = 3'd0,
    ST_OK         = 3'd1,
    ST_BADSUM     = 3'd2,
    ST_CLIPPED    = 3'd3,
    ST_INCOMPLETE = 3'd4
  } status_t;

  typedef enum logic [8:0] {
    PH_HUNT  = 9'b000000001,
    PH_SYNC2 = 9'b000000010,
    PH_LENHI = 9'b000000100,
    PH_LENLO = 9'b000001000,
    PH_ID    = 9'b000010000,
    PH_BODY  = 9'b000100000,
    PH_SUM   = 9'b001000000,
    PH_CR    = 9'b010000000,
    PH_LF    = 9'b100000000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] running_xor;
    logic [7:0] payload_count;
    logic [7:0] body_length;
    logic [7:0] frame_id;
    logic [7:0] ok_counter;
  } state_t;

  typedef struct packed {
    status_t    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] message_id;
    logic       is_location;
    logic [7:0] good_frames;
  } result_t;

endpackage

`default_nettype wire

// ===== design/bgfp_if.sv =====
// Valid/ready channel interfaces of the binary GPS frame parser.
// Self-contained; used by the top level and the testbench.
`default_nettype none

interface bgfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bgfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] message_id;
  logic       is_location;
  logic [7:0] good_frames;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output payload_index, output message_id, output is_location,
                  output good_frames, input ready);
  modport sink (input valid, input status, input payload_valid, input payload_byte,
                input payload_index, input message_id, input is_location,
                input good_frames, output ready);
endinterface

`default_nettype wire

// ===== design/bgfp_step.sv =====
// Per-byte deframing step: next state and result for one received byte.
// Depends on bgfp_pkg.
`default_nettype none

module bgfp_step #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       location_msg_id,
  input  bgfp_pkg::state_t cur,
  output bgfp_pkg::state_t nxt,
  output bgfp_pkg::result_t res
);
  import bgfp_pkg::*;

  localparam logic [7:0] MaxPay = 8'(MAX_PAYLOAD);

  logic [7:0] count_inc;
  logic [7:0] ok_inc;
  status_t    status;

  assign count_inc = cur.payload_count + 8'd1;
  assign ok_inc    = cur.ok_counter + 8'd1;

  always_comb begin
    nxt               = cur;
    status            = ST_MORE;
    res.payload_valid = 1'b0;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    res.is_location   = 1'b0;
    unique case (cur.phase)
      PH_HUNT: begin
        if (rx_byte == SYNC_FIRST) nxt.phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        nxt.phase = (rx_byte == SYNC_SECOND) ? PH_LENHI : PH_HUNT;
      end
      PH_LENHI: begin
        nxt.phase = PH_LENLO;
      end
      PH_LENLO: begin
        nxt.body_length = rx_byte;
        nxt.phase       = PH_ID;
      end
      PH_ID: begin
        nxt.frame_id      = rx_byte;
        nxt.running_xor   = rx_byte;
        nxt.payload_count = 8'd0;
        nxt.body_length   = cur.body_length - 8'd1;
        nxt.phase         = (cur.body_length != 8'd1) ? PH_BODY : PH_SUM;
      end
      PH_BODY: begin
        if (cur.payload_count < MaxPay) begin
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = cur.payload_count;
        end
        nxt.running_xor   = cur.running_xor ^ rx_byte;
        nxt.payload_count = count_inc;
        if (count_inc >= cur.body_length) nxt.phase = PH_SUM;
      end
      PH_SUM: begin
        if (rx_byte == cur.running_xor) begin
          nxt.phase = PH_CR;
        end else begin
          nxt.phase = PH_HUNT;
          status    = ST_BADSUM;
        end
      end
      PH_CR: begin
        if (rx_byte == BYTE_CR) nxt.phase = PH_LF;
      end
      PH_LF: begin
        nxt.phase       = PH_HUNT;
        res.is_location = (cur.frame_id == location_msg_id);
        if (rx_byte == BYTE_LF) begin
          status = (cur.payload_count <= MaxPay) ? ST_OK : ST_CLIPPED;
        end else begin
          status = ST_INCOMPLETE;
        end
      end
      default: begin
        nxt.phase = PH_HUNT;
        status    = ST_INCOMPLETE;
      end
    endcase
    if (status == ST_OK) begin
      nxt.ok_counter = (ok_inc == 8'd0) ? 8'd1 : ok_inc;
    end
    res.status      = status;
    res.message_id  = nxt.frame_id;
    res.good_frames = nxt.ok_counter;
  end

endmodule

`default_nettype wire

// ===== design/binary_gps_frame_parser.sv =====
// Top level of the binary GPS frame parser: channel handshake, state and
// result registers. Depends on bgfp_pkg, bgfp_if and bgfp_step.
//
// Usage:
//   in_bus carries one received byte per beat; out_bus returns exactly one
//   result beat per input beat, in order: status, a streamed payload byte
//   with its index, the frame ID, the location flag and the good-frame count.
//   cfg_we/cfg_wdata write the location message ID (reset value 168).
// Output: the result of a byte is registered and shown on out_bus in the
//   cycle after the byte's beat is taken.
// Throughput: one byte per cycle while out_bus.ready is high; the per-byte
//   state update is one pass of combinational logic from the state registers into the result register.
// Stall: in_bus.ready is high while the result register is empty or its
//   beat is taken in the same cycle; a held result stays stable.
// Reset: rst_n is synchronous, active low; it returns the deframer to
//   hunting for the first sync byte, clears the counters and empties the
//   result register.
`default_nettype none

module binary_gps_frame_parser #(
  parameter int MAX_PAYLOAD = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  bgfp_in_if.sink    in_bus,
  bgfp_out_if.source out_bus,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import bgfp_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  result_t    res_r;
  result_t    res_nxt;
  logic       out_valid_r;
  logic [7:0] loc_id_r;
  logic       take;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign take         = in_bus.valid && in_bus.ready;

  bgfp_step #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_step (
    .rx_byte         (in_bus.rx_byte),
    .location_msg_id (loc_id_r),
    .cur             (state_r),
    .nxt             (state_nxt),
    .res             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_id_r <= LOC_ID_RESET;
    end else if (cfg_we) begin
      loc_id_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_HUNT;
      state_r.running_xor   <= 8'd0;
      state_r.payload_count <= 8'd0;
      state_r.body_length   <= 8'd0;
      state_r.frame_id      <= 8'd0;
      state_r.ok_counter    <= 8'd0;
      out_valid_r           <= 1'b0;
    end else begin
      if (take) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.status        = res_r.status;
  assign out_bus.payload_valid = res_r.payload_valid;
  assign out_bus.payload_byte  = res_r.payload_byte;
  assign out_bus.payload_index = res_r.payload_index;
  assign out_bus.message_id    = res_r.message_id;
  assign out_bus.is_location   = res_r.is_location;
  assign out_bus.good_frames   = res_r.good_frames;

endmodule

`default_nettype wire

// ===== design/bgfp_checker.sv =====
// Port-level checker of the binary GPS frame parser, with its bind.
// Depends on bgfp_pkg and binary_gps_frame_parser_assert.svh.
`default_nettype none
`include "binary_gps_frame_parser_assert.svh"

module bgfp_checker #(
  parameter int MAX_PAYLOAD = 128
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       payload_valid,
  input logic [7:0] payload_index,
  input logic       is_location,
  input logic [7:0] good_frames
);
  import bgfp_pkg::*;

  localparam logic [7:0] MaxPay = 8'(MAX_PAYLOAD);

  `BGFP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(good_frames))
  `BGFP_ASSERT_IMP(a_payload_more, out_valid && payload_valid, status == ST_MORE)
  `BGFP_ASSERT_IMP(a_payload_limit, out_valid && payload_valid, payload_index < MaxPay)
  `BGFP_ASSERT_IMP(a_loc_frame_end, out_valid && is_location, status != ST_MORE && status != ST_BADSUM)
  `BGFP_ASSERT_IMP(a_ok_count, out_valid && status == ST_OK, good_frames != 8'd0)

endmodule

bind binary_gps_frame_parser bgfp_checker #(
  .MAX_PAYLOAD(MAX_PAYLOAD)
) u_bgfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .status        (out_bus.status),
  .payload_valid (out_bus.payload_valid),
  .payload_index (out_bus.payload_index),
  .is_location   (out_bus.is_location),
  .good_frames   (out_bus.good_frames)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench of the binary GPS frame parser: directed table, then random frames and noise.
// Checks each result beat against a byte-level deframing predictor or a directed entry.
// Depends on bgfp_pkg, bgfp_if and binary_gps_frame_parser.
`timescale 1ns / 1ps

module tb_top;
  import bgfp_pkg::*;

  localparam int MAX_PAY      = 128;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  bgfp_in_if  in_bus ();
  bgfp_out_if out_bus ();

  binary_gps_frame_parser #(.MAX_PAYLOAD(MAX_PAY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  phase_t     st_phase;
  logic [7:0] st_xor;
  logic [7:0] st_count;
  logic [7:0] st_len;
  logic [7:0] st_id;
  logic [7:0] st_good;
  logic [7:0] loc_id_reg;

  result_t pending_results[$];
  int      err_cnt;
  int      sent_cnt;
  int      burst_left;
  int      cycles;
  int      seen_status[5];
  int      loc_writes;
  bit      long_hold_req;

  logic [7:0] dir_bytes[$];
  result_t    dir_expect[int];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic result_t make_result(status_t s, logic pv, logic [7:0] pb, logic [7:0] pi,
                                          logic [7:0] id, logic loc, logic [7:0] gf);
    result_t r;
    r.status        = s;
    r.payload_valid = pv;
    r.payload_byte  = pb;
    r.payload_index = pi;
    r.message_id    = id;
    r.is_location   = loc;
    r.good_frames   = gf;
    return r;
  endfunction

  function automatic result_t deframe_byte(logic [7:0] c);
    result_t r;
    r        = '0;
    r.status = ST_MORE;
    case (st_phase)
      PH_HUNT: begin
        if (c == SYNC_FIRST) st_phase = PH_SYNC2;
      end
      PH_SYNC2: st_phase = (c == SYNC_SECOND) ? PH_LENHI : PH_HUNT;
      PH_LENHI: st_phase = PH_LENLO;
      PH_LENLO: begin
        st_len   = c;
        st_phase = PH_ID;
      end
      PH_ID: begin
        st_id    = c;
        st_xor   = c;
        st_count = 8'd0;
        st_len   = st_len - 8'd1;
        st_phase = (st_len != 8'd0) ? PH_BODY : PH_SUM;
      end
      PH_BODY: begin
        if (st_count < MAX_PAY) begin
          r.payload_valid = 1'b1;
          r.payload_byte  = c;
          r.payload_index = st_count;
        end
        st_xor   = st_xor ^ c;
        st_count = st_count + 8'd1;
        if (st_count >= st_len) st_phase = PH_SUM;
      end
      PH_SUM: begin
        if (c == st_xor) begin
          st_phase = PH_CR;
        end else begin
          st_phase = PH_HUNT;
          r.status = ST_BADSUM;
        end
      end
      PH_CR: begin
        if (c == BYTE_CR) st_phase = PH_LF;
      end
      PH_LF: begin
        st_phase      = PH_HUNT;
        r.is_location = (st_id == loc_id_reg);
        if (c == BYTE_LF) r.status = (st_count <= MAX_PAY) ? ST_OK : ST_CLIPPED;
        else r.status = ST_INCOMPLETE;
      end
      default: begin
        st_phase = PH_HUNT;
        r.status = ST_INCOMPLETE;
      end
    endcase
    if (r.status == ST_OK) begin
      st_good = st_good + 8'd1;
      if (st_good == 8'd0) st_good = 8'd1;
    end
    r.message_id  = st_id;
    r.good_frames = st_good;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit use_typed = 1'b0,
                           input result_t typed_r = '0);
    int      gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 4);
      if (gap > 0) begin
        in_bus.valid   <= 1'b0;
        in_bus.rx_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    r = deframe_byte(b);
    pending_results.push_back(use_typed ? typed_r : r);
    seen_status[r.status]++;
    sent_cnt++;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] id, input bit bad_sum,
                            input int junk, input bit lf_ok);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    int         k;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'($urandom));
    send_byte(len);
    send_byte(id);
    sum = id;
    n   = int'(8'(len - 8'd1));
    for (k = 0; k < n; k++) begin
      b   = 8'($urandom);
      sum = sum ^ b;
      send_byte(b);
    end
    if (bad_sum) begin
      send_byte(sum ^ 8'($urandom_range(1, 255)));
      return;
    end
    send_byte(sum);
    for (k = 0; k < junk; k++) begin
      b = 8'($urandom);
      if (b == BYTE_CR) b = b ^ 8'h01;
      send_byte(b);
    end
    send_byte(BYTE_CR);
    if (lf_ok) begin
      send_byte(BYTE_LF);
    end else begin
      b = 8'($urandom);
      if (b == BYTE_LF) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  task automatic write_loc_id(input logic [7:0] v);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    loc_id_reg = v;
    loc_writes++;
  endtask

  task automatic random_traffic(input int beats);
    int         goal;
    int         kind;
    int         sel;
    int         k;
    logic [7:0] len;
    logic [7:0] id;
    goal = sent_cnt + beats;
    while (sent_cnt < goal) begin
      kind = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      if (sel < 88) len = 8'($urandom_range(1, 12));
      else if (sel < 96) len = 8'($urandom_range(126, 131));
      else if (sel < 98) len = 8'd0;
      else len = 8'($urandom);
      id = ($urandom_range(0, 1) == 0) ? loc_id_reg : 8'($urandom);
      if (kind < 70) begin
        send_frame(len, id, 1'b0, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0, 1'b1);
      end else if (kind < 80) begin
        send_frame(len, id, 1'b1, 0, 1'b1);
      end else if (kind < 87) begin
        send_frame(len, id, 1'b0, $urandom_range(0, 3), 1'b0);
      end else if (kind < 93) begin
        send_byte(SYNC_FIRST);
        send_byte(8'($urandom));
      end else begin
        sel = $urandom_range(1, 8);
        for (k = 0; k < sel; k++) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    int mode;
    int stretch_left;
    int hold_left;
    int phase_cnt;
    mode         = 0;
    stretch_left = 0;
    hold_left    = 0;
    phase_cnt    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode         = $urandom_range(0, 3);
          stretch_left = $urandom_range(20, 150);
        end
        stretch_left--;
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          2: out_bus.ready <= ((phase_cnt % 4) != 0);
          default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d", out_bus.status);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_bus.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_bus.status);
          err_cnt++;
        end
        if (out_bus.payload_valid !== want.payload_valid) begin
          $error("payload_valid expected %0d actual %0d", want.payload_valid,
                 out_bus.payload_valid);
          err_cnt++;
        end
        if (out_bus.payload_byte !== want.payload_byte) begin
          $error("payload_byte expected %0d actual %0d", want.payload_byte, out_bus.payload_byte);
          err_cnt++;
        end
        if (out_bus.payload_index !== want.payload_index) begin
          $error("payload_index expected %0d actual %0d", want.payload_index,
                 out_bus.payload_index);
          err_cnt++;
        end
        if (out_bus.message_id !== want.message_id) begin
          $error("message_id expected %0d actual %0d", want.message_id, out_bus.message_id);
          err_cnt++;
        end
        if (out_bus.is_location !== want.is_location) begin
          $error("is_location expected %0d actual %0d", want.is_location, out_bus.is_location);
          err_cnt++;
        end
        if (out_bus.good_frames !== want.good_frames) begin
          $error("good_frames expected %0d actual %0d", want.good_frames, out_bus.good_frames);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int i;
    err_cnt        = 0;
    sent_cnt       = 0;
    burst_left     = 0;
    cycles         = 0;
    loc_writes     = 0;
    long_hold_req  = 1'b0;
    seen_status    = '{default: 0};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 8'd0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = 8'd0;
    st_phase       = PH_HUNT;
    st_xor         = 8'd0;
    st_count       = 8'd0;
    st_len         = 8'd0;
    st_id          = 8'd0;
    st_good        = 8'd0;
    loc_id_reg     = LOC_ID_RESET;

    dir_bytes = '{8'hFF,
                  8'hA0, 8'hA1, 8'h00, 8'h02, 8'hA8, 8'h55, 8'hFD, 8'h0D, 8'h0A,
                  8'hA0, 8'h00,
                  8'hA0, 8'hA1, 8'hFF, 8'h01, 8'h07, 8'h00,
                  8'hA0, 8'hA1, 8'h00, 8'h01, 8'h00, 8'h00, 8'h0D, 8'h55};
    dir_expect[0]  = make_result(ST_MORE, 1'b0, 8'h00, 8'd0, 8'h00, 1'b0, 8'd0);
    dir_expect[6]  = make_result(ST_MORE, 1'b1, 8'h55, 8'd0, 8'hA8, 1'b0, 8'd0);
    dir_expect[9]  = make_result(ST_OK, 1'b0, 8'h00, 8'd0, 8'hA8, 1'b1, 8'd1);
    dir_expect[11] = make_result(ST_MORE, 1'b0, 8'h00, 8'd0, 8'hA8, 1'b0, 8'd1);
    dir_expect[17] = make_result(ST_BADSUM, 1'b0, 8'h00, 8'd0, 8'h07, 1'b0, 8'd1);
    dir_expect[25] = make_result(ST_INCOMPLETE, 1'b0, 8'h00, 8'd0, 8'h00, 1'b0, 8'd1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < dir_bytes.size(); i++) begin
      if (dir_expect.exists(i)) send_byte(dir_bytes[i], 1'b1, dir_expect[i]);
      else send_byte(dir_bytes[i]);
    end
    send_frame(8'd0, LOC_ID_RESET, 1'b0, 0, 1'b1);
    send_frame(8'(MAX_PAY + 1), 8'h3C, 1'b0, 0, 1'b1);

    write_loc_id(8'd0);
    random_traffic(370);
    write_loc_id(8'hFF);
    long_hold_req = 1'b1;
    random_traffic(370);
    write_loc_id(8'($urandom));
    random_traffic(370);
    write_loc_id(8'($urandom));
    random_traffic(370);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d byte beats over %0d location ID settings in %0d cycles",
             sent_cnt, loc_writes + 1, cycles);
    $display("statuses: more %0d, ok %0d, bad checksum %0d, clipped %0d, incomplete %0d",
             seen_status[ST_MORE], seen_status[ST_OK], seen_status[ST_BADSUM],
             seen_status[ST_CLIPPED], seen_status[ST_INCOMPLETE]);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
